// File: rtl/core/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, codes and the glyph table of the seven-segment scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned SEG_COUNT   = 7;
  localparam int unsigned DIGIT_LINES = 4;
  localparam int unsigned CODE_W      = 5;
  localparam int unsigned GLYPH_COUNT = 32;

  localparam logic [CODE_W-1:0] BLANK_CODE  = 5'd31;
  localparam logic [7:0]        BLANK_RESET = 8'd64;

  typedef enum logic {
    FUNC_TICK  = 1'b0,
    FUNC_WRITE = 1'b1
  } ssd_func_t;

  typedef enum logic {
    REG_BLANK_TICKS  = 1'b0,
    REG_COMMON_ANODE = 1'b1
  } ssd_reg_t;

  typedef struct packed {
    ssd_func_t         func;
    logic [1:0]        digit_index;
    logic [CODE_W-1:0] char_code;
  } ssd_in_t;

  typedef struct packed {
    logic [SEG_COUNT-1:0]   segment_enable;
    logic [SEG_COUNT-1:0]   segment_level;
    logic [DIGIT_LINES-1:0] digit_enable;
    logic [DIGIT_LINES-1:0] digit_level;
  } ssd_out_t;

  typedef struct packed {
    ssd_reg_t   index;
    logic [7:0] wdata;
  } ssd_cfg_wr_t;

  // Register contents as seen by the scan logic
  typedef struct packed {
    logic [7:0] blank_ticks;
    logic       common_anode;
  } ssd_cfg_t;

  // bit6 = a ... bit0 = g
  localparam logic [SEG_COUNT-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
    7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70,
    7'h7F, 7'h7B, 7'h08, 7'h63, 7'h1D, 7'h1F, 7'h47, 7'h4E,
    7'h0F, 7'h37, 7'h15, 7'h05, 7'h3C, 7'h3D, 7'h0E, 7'h10,
    7'h4F, 7'h77, 7'h40, 7'h41, 7'h49, 7'h66, 7'h72, 7'h00
  };

  function automatic logic [2:0] count_lit(input logic [SEG_COUNT-1:0] pat);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < SEG_COUNT; i++) begin
      n = n + {2'b00, pat[i]};
    end
    return n;
  endfunction

endpackage

// File: rtl/core/ssd_chan_if.sv
// ----------------------------------------------------------------------------
// ssd_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface ssd_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: rtl/core/seven_segment_scan_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Multiplexed seven-segment display driver with equal-brightness scan.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   per transaction
//  in_ch    in   func, digit_index, char_code              tick or char write
//  out_ch   out  segment/digit enables and levels          one per tick
//  cfg_ch   in   index, wdata                              register write
//
//  One item per cycle sustained while out_ch is ready; a tick's result
//  passes through the input register, loaded at the accepting edge, and
//  then the result register before it is offered on out_ch.
//  Character writes give no result and never wait on out_ch.
//  Reset blanks every digit, clears the scan and loads a 64-tick blank gap.
//  A stalled out_ch holds one result; a second tick then waits in the input
//  register and in_ch.ready drops.  cfg_ch is always ready.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  ssd_chan_if.sink   in_ch,
  ssd_chan_if.source out_ch,
  ssd_chan_if.sink   cfg_ch
);

  ssd_pkg::ssd_cfg_t cfg;

  ssd_chan_if #(.payload_t(ssd_pkg::ssd_out_t)) res_ch ();

  ssd_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  ssd_scan_core #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_scan_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .res_ch (res_ch.source),
    .cfg    (cfg)
  );

  ssd_out_stage u_out_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .res_ch (res_ch.sink),
    .out_ch (out_ch)
  );

endmodule

// File: rtl/core/ssd_cfg_regs.sv
// ----------------------------------------------------------------------------
// ssd_cfg_regs
// Configuration registers: blank interval and pin polarity.
// ----------------------------------------------------------------------------
module ssd_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  ssd_chan_if.sink         cfg_ch,
  output ssd_pkg::ssd_cfg_t cfg
);

  logic [7:0] blank_ticks_r;
  logic       common_anode_r;

  assign cfg_ch.ready     = 1'b1;
  assign cfg.blank_ticks  = blank_ticks_r;
  assign cfg.common_anode = common_anode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_ticks_r  <= ssd_pkg::BLANK_RESET;
      common_anode_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        ssd_pkg::REG_BLANK_TICKS:  blank_ticks_r  <= cfg_ch.data.wdata;
        ssd_pkg::REG_COMMON_ANODE: common_anode_r <= cfg_ch.data.wdata[0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/ssd_scan_core.sv
// ----------------------------------------------------------------------------
// ssd_scan_core
// Input register, character store and scan counters; works out the pin
// pattern for each tick in one pass.
// ----------------------------------------------------------------------------
module ssd_scan_core #(
  parameter int DIGIT_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  ssd_chan_if.sink          in_ch,
  ssd_chan_if.source        res_ch,
  input  ssd_pkg::ssd_cfg_t cfg
);

  localparam int PW = $clog2(DIGIT_COUNT);

  // input stage
  logic             item_valid_r;
  ssd_pkg::ssd_in_t item_r;
  logic             advance;

  // scan state
  logic [ssd_pkg::CODE_W-1:0]    char_store_r   [DIGIT_COUNT];
  logic [ssd_pkg::CODE_W-1:0]    char_store_nxt [DIGIT_COUNT];
  logic [PW-1:0]                 scan_pos_r, scan_pos_nxt;
  logic [2:0]                    on_count_r, on_count_nxt;
  logic [7:0]                    blank_count_r, blank_count_nxt;
  logic [ssd_pkg::SEG_COUNT-1:0] shown_seg_r, shown_seg_nxt;
  logic [DIGIT_COUNT-1:0]        shown_digit_r, shown_digit_nxt;

  logic [ssd_pkg::SEG_COUNT-1:0]         glyph;
  logic [DIGIT_COUNT+ssd_pkg::DIGIT_LINES-1:0] digit_wide;
  logic [ssd_pkg::DIGIT_LINES-1:0]       digit_pins;
  logic                                  is_tick;

  assign is_tick      = (item_r.func == ssd_pkg::FUNC_TICK);
  assign advance      = item_valid_r && (!is_tick || res_ch.ready);
  assign in_ch.ready  = !item_valid_r || advance;
  assign res_ch.valid = item_valid_r && is_tick;

  always_comb begin
    char_store_nxt  = char_store_r;
    scan_pos_nxt    = scan_pos_r;
    on_count_nxt    = on_count_r;
    blank_count_nxt = blank_count_r;
    shown_seg_nxt   = shown_seg_r;
    shown_digit_nxt = shown_digit_r;
    glyph           = ssd_pkg::GLYPH_ROM[char_store_r[scan_pos_r]];

    if (!is_tick) begin
      // writes past the last digit fall through the decoder
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        if (int'(item_r.digit_index) == i) begin
          char_store_nxt[i] = item_r.char_code;
        end
      end
    end else if (on_count_r != 3'd0) begin
      on_count_nxt = on_count_r - 3'd1;
    end else begin
      shown_seg_nxt   = '0;
      shown_digit_nxt = '0;
      if (blank_count_r != 8'd0) begin
        blank_count_nxt = blank_count_r - 8'd1;
      end else begin
        shown_seg_nxt   = glyph;
        shown_digit_nxt = {{(DIGIT_COUNT-1){1'b0}}, 1'b1} << scan_pos_r;
        // on-time follows segment count for even brightness
        on_count_nxt    = ssd_pkg::count_lit(glyph);
        blank_count_nxt = cfg.blank_ticks;
        if (scan_pos_r == PW'(DIGIT_COUNT - 1)) begin
          scan_pos_nxt = '0;
        end else begin
          scan_pos_nxt = scan_pos_r + PW'(1);
        end
      end
    end
  end

  // digit lines beyond the four pins are dropped, fewer are zero-padded
  assign digit_wide = {{ssd_pkg::DIGIT_LINES{1'b0}}, shown_digit_nxt};
  assign digit_pins = digit_wide[ssd_pkg::DIGIT_LINES-1:0];

  assign res_ch.data.segment_enable = shown_seg_nxt;
  assign res_ch.data.segment_level  = cfg.common_anode ? '0 : shown_seg_nxt;
  assign res_ch.data.digit_enable   = digit_pins;
  assign res_ch.data.digit_level    = cfg.common_anode ? digit_pins : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r <= in_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        char_store_r[i] <= ssd_pkg::BLANK_CODE;
      end
      scan_pos_r    <= '0;
      on_count_r    <= 3'd0;
      blank_count_r <= ssd_pkg::BLANK_RESET;
      shown_seg_r   <= '0;
      shown_digit_r <= '0;
    end else if (advance) begin
      char_store_r  <= char_store_nxt;
      scan_pos_r    <= scan_pos_nxt;
      on_count_r    <= on_count_nxt;
      blank_count_r <= blank_count_nxt;
      shown_seg_r   <= shown_seg_nxt;
      shown_digit_r <= shown_digit_nxt;
    end
  end

endmodule

// File: rtl/core/ssd_out_stage.sv
// ----------------------------------------------------------------------------
// ssd_out_stage
// Result register decoupling the scan logic from the output channel.
// ----------------------------------------------------------------------------
module ssd_out_stage (
  input  logic       clk,
  input  logic       rst_n,
  ssd_chan_if.sink   res_ch,
  ssd_chan_if.source out_ch
);

  logic              out_valid_r;
  ssd_pkg::ssd_out_t out_data_r;

  assign res_ch.ready = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ch.ready) begin
      out_valid_r <= res_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ch.ready && res_ch.valid) begin
      out_data_r <= res_ch.data;
    end
  end

endmodule

// File: tb/seven_segment_scan_driver_tb.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_tb
// Drives character writes and timer ticks into the scan driver, changes the
// blank gap and the polarity between phases, and checks every pin pattern
// against a scan tracker held in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module seven_segment_scan_driver_tb;

  localparam int DIGITS = 4;
  localparam int SETTLE_CYCLES = 4;

  // bit6 = a ... bit0 = g
  localparam logic [6:0] SEGMENT_MAP [32] = '{
    7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70,
    7'h7F, 7'h7B, 7'h08, 7'h63, 7'h1D, 7'h1F, 7'h47, 7'h4E,
    7'h0F, 7'h37, 7'h15, 7'h05, 7'h3C, 7'h3D, 7'h0E, 7'h10,
    7'h4F, 7'h77, 7'h40, 7'h41, 7'h49, 7'h66, 7'h72, 7'h00
  };

  class scan_scoreboard;
    logic [7:0] gap_ticks;
    logic       anode_mode;
    logic [4:0] char_store [DIGITS];
    int         scan_pos;
    logic [2:0] on_left;
    logic [7:0] blank_left;
    logic [6:0] lit_segments;
    logic [3:0] lit_digit;
    ssd_pkg::ssd_out_t pins_due [$];
    int unsigned mismatches;

    function new();
      gap_ticks    = ssd_pkg::BLANK_RESET;
      anode_mode   = 1'b1;
      foreach (char_store[i]) char_store[i] = ssd_pkg::BLANK_CODE;
      scan_pos     = 0;
      on_left      = 3'd0;
      blank_left   = ssd_pkg::BLANK_RESET;
      lit_segments = '0;
      lit_digit    = '0;
      mismatches   = 0;
    endfunction

    function void set_register(ssd_pkg::ssd_reg_t idx, logic [7:0] value);
      if (idx == ssd_pkg::REG_BLANK_TICKS) gap_ticks = value;
      else anode_mode = value[0];
    endfunction

    // Called for every accepted input transaction
    function void note_item(ssd_pkg::ssd_in_t it);
      ssd_pkg::ssd_out_t pins;
      logic [6:0]        pat;
      if (it.func == ssd_pkg::FUNC_WRITE) begin
        if (it.digit_index < DIGITS) char_store[it.digit_index] = it.char_code;
        return;
      end
      if (on_left != 0) begin
        on_left = on_left - 3'd1;
      end else begin
        lit_segments = '0;
        lit_digit    = '0;
        if (blank_left != 0) begin
          blank_left = blank_left - 8'd1;
        end else begin
          pat          = SEGMENT_MAP[char_store[scan_pos]];
          lit_segments = pat;
          lit_digit    = 4'(1 << scan_pos);
          on_left      = 3'($countones(pat));
          blank_left   = gap_ticks;
          scan_pos     = (scan_pos + 1) % DIGITS;
        end
      end
      pins.segment_enable = lit_segments;
      pins.segment_level  = anode_mode ? '0 : lit_segments;
      pins.digit_enable   = lit_digit;
      pins.digit_level    = anode_mode ? lit_digit : '0;
      pins_due.push_back(pins);
    endfunction

    function void compare_field(string field, logic [6:0] want, logic [6:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_pins(ssd_pkg::ssd_out_t got);
      ssd_pkg::ssd_out_t want;
      if (pins_due.size() == 0) begin
        $error("pin pattern with nothing due: %p", got);
        mismatches++;
        return;
      end
      want = pins_due.pop_front();
      compare_field("segment_enable", want.segment_enable, got.segment_enable);
      compare_field("segment_level", want.segment_level, got.segment_level);
      compare_field("digit_enable", 7'(want.digit_enable), 7'(got.digit_enable));
      compare_field("digit_level", 7'(want.digit_level), 7'(got.digit_level));
    endfunction

    function int unsigned pending();
      return pins_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ssd_chan_if #(.payload_t(ssd_pkg::ssd_in_t))     in_ch ();
  ssd_chan_if #(.payload_t(ssd_pkg::ssd_out_t))    out_ch ();
  ssd_chan_if #(.payload_t(ssd_pkg::ssd_cfg_wr_t)) cfg_ch ();

  seven_segment_scan_driver #(.DIGIT_COUNT(DIGITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  scan_scoreboard sb = new();

  bit          src_quiet;
  bit          sink_quiet;
  int unsigned sink_hold;
  int unsigned items_sent;

  // Result side: random stalls, plus a long hold-off on request
  initial begin : pin_sink
    int unsigned stall;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_pins(out_ch.data);
        stall = sink_quiet ? 0 : $urandom_range(0, 10);
      end else if (stall != 0) begin
        stall--;
      end
      if (sink_hold != 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end
      out_ch.ready <= (stall == 0);
    end
  end

  function automatic ssd_pkg::ssd_in_t make_item(int unsigned tick_pct);
    ssd_pkg::ssd_in_t it;
    it.func        = ($urandom_range(0, 99) < tick_pct) ? ssd_pkg::FUNC_TICK
                                                         : ssd_pkg::FUNC_WRITE;
    it.digit_index = 2'($urandom_range(0, 3));
    it.char_code   = 5'($urandom_range(0, 31));
    return it;
  endfunction

  function automatic ssd_pkg::ssd_in_t char_write(logic [1:0] digit, logic [4:0] code);
    ssd_pkg::ssd_in_t it;
    it.func        = ssd_pkg::FUNC_WRITE;
    it.digit_index = digit;
    it.char_code   = code;
    return it;
  endfunction

  // valid stays high after a transaction; it drops when a gap is drawn or results are drained
  task automatic send_item(input ssd_pkg::ssd_in_t it);
    int unsigned gap;
    gap = src_quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= ssd_pkg::ssd_in_t'(8'($urandom));
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
    items_sent++;
  endtask

  // Writes still in flight give no result, hence the settle time
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic [7:0] gap_ticks, input logic anode);
    logic [7:0] wdata;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= ssd_pkg::ssd_cfg_wr_t'{index: ssd_pkg::REG_BLANK_TICKS,
                                           wdata: gap_ticks};
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_register(ssd_pkg::REG_BLANK_TICKS, gap_ticks);
    wdata = {7'($urandom), anode};
    cfg_ch.data <= ssd_pkg::ssd_cfg_wr_t'{index: ssd_pkg::REG_COMMON_ANODE,
                                          wdata: wdata};
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_register(ssd_pkg::REG_COMMON_ANODE, wdata);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned phase_len;
    int unsigned phase_no;
    logic [7:0]  gap_ticks;
    src_quiet    = 1'b0;
    sink_quiet   = 1'b0;
    sink_hold    = 0;
    items_sent   = 0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Common cathode, no gap: full glyph, empty glyph, zero and one segment
    write_settings(8'd0, 1'b0);
    send_item(char_write(2'd0, 5'd8));
    send_item(char_write(2'd1, ssd_pkg::BLANK_CODE));
    send_item(char_write(2'd2, 5'd0));
    send_item(char_write(2'd3, 5'd23));
    repeat (90) send_item(make_item(100));
    drain_results();
    // polarity flip, usually while a digit is still held
    write_settings(8'd0, 1'b1);
    repeat (12) send_item(make_item(100));
    drain_results();

    phase_no = 0;
    while (items_sent < 350) begin
      unique case (phase_no % 4)
        0: gap_ticks = 8'd0;
        1: gap_ticks = 8'd1;
        2: gap_ticks = 8'($urandom_range(2, 6));
        default: gap_ticks = 8'($urandom_range(0, 12));
      endcase
      write_settings(gap_ticks, 1'($urandom_range(0, 1)));
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      phase_len  = $urandom_range(30, 60);
      for (int i = 0; i < phase_len; i++) begin
        if (phase_no == 0 && i == 5) begin
          // back up the block: sink holds off, sender keeps offering
          src_quiet = 1'b1;
          sink_hold = 40;
        end
        if (phase_no == 1 && i == phase_len / 2) drain_results();
        send_item(make_item(75));
      end
      drain_results();
      phase_no++;
    end

    // widest gap, almost only ticks so the reload shows
    write_settings(8'd255, 1'($urandom_range(0, 1)));
    src_quiet  = 1'b0;
    sink_quiet = 1'b0;
    repeat (300) send_item(make_item(95));
    drain_results();
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("seven_segment_scan_driver_tb: done, clean");
    end else begin
      $display("seven_segment_scan_driver_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("seven_segment_scan_driver_tb: done, errors");
    $finish;
  end

endmodule
